// File: rtl/lru_kvc_pkg.sv
package lru_kvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KIND_W          = 2;
   localparam int KEY_W           = 16;
   localparam int VALUE_W         = 32;
   localparam int CAP_W           = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic [KIND_W-1:0] KIND_GET    = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_PUT    = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_DELETE = KIND_W'(2);

   // What every entry cell does with the item in the decision stage.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_TOUCH,
      ACT_WRITE,
      ACT_INSERT,
      ACT_REMOVE
   } act_type;

   typedef struct packed {
      logic    fire;
      act_type act;
   } ctl_type;

endpackage

// File: rtl/lru_kvc_if.sv
interface lru_kvc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lru_kvc_pkg::KIND_W-1:0]       kind;
   logic [lru_kvc_pkg::KEY_W-1:0]        key;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lru_kvc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [lru_kvc_pkg::KEY_W-1:0]        hit_key;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] hit_value;

   modport source (output valid, output found, output hit_key, output hit_value, input ready);
   modport sink   (input valid, input found, input hit_key, input hit_value, output ready);
endinterface

// File: rtl/lru_key_value_cache.sv
// Fully associative key/value store with least-recently-used replacement,
// built from ENTRIES flip-flop cells. An accepted beat is held in an input
// register; from there every cell compares its key in parallel, the recency
// ranks of all cells are updated and, for a get, the answer is loaded into the
// output register. One item is taken every cycle when the input side does not
// stall; this rate is set by the key compare and rank update across the cells.
// The input side stalls only while a get answer cannot enter an occupied
// output register.
module lru_key_value_cache #(
   parameter int ENTRIES = lru_kvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   lru_kvc_req_if.sink                    req,
   lru_kvc_rsp_if.source                  rsp,
   input  logic                           csr_write_enable,
   input  logic [lru_kvc_pkg::CAP_W-1:0]  csr_write_data
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lru_kvc_pkg::CAP_W) ? OCC_W : lru_kvc_pkg::CAP_W;

   logic [lru_kvc_pkg::CAP_W-1:0]          capacity_ff;
   logic [OCC_W-1:0]                       occ_ff, occ_in;

   logic                                   stg_valid_ff;
   logic [lru_kvc_pkg::KIND_W-1:0]         stg_kind_ff;
   logic [lru_kvc_pkg::KEY_W-1:0]          stg_key_ff;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] stg_value_ff;

   logic                                   rsp_valid_ff;
   logic                                   rsp_found_ff;
   logic [lru_kvc_pkg::KEY_W-1:0]          rsp_key_ff;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] rsp_value_ff;

   logic [ENTRIES-1:0]                     match_vec, valid_vec, victim_vec;
   logic [ENTRIES-1:0]                     free_vec, first_free_vec, sel_vec;
   logic [RANK_W-1:0]                      rank_arr [ENTRIES];
   logic [lru_kvc_pkg::KEY_W-1:0]          key_arr [ENTRIES];
   logic signed [lru_kvc_pkg::VALUE_W-1:0] value_arr [ENTRIES];

   logic                                   hit, is_get, fire, out_free, full;
   logic [RANK_W-1:0]                      hit_rank, lru_rank;
   logic [lru_kvc_pkg::KEY_W-1:0]          hit_key;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] hit_value;
   logic [CMP_W-1:0]                       cap_ext, eff_cap;
   lru_kvc_pkg::ctl_type                   ctl;

   assign is_get    = (stg_kind_ff == lru_kvc_pkg::KIND_GET);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = stg_valid_ff && (!is_get || out_free);
   assign req.ready = !stg_valid_ff || fire;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.hit_key   = rsp_key_ff;
   assign rsp.hit_value = rsp_value_ff;

   // A capacity of zero acts as one, and anything above the store size as the store size.
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign full = (CMP_W'(occ_ff) >= eff_cap);

   // Ranks of valid entries are always 0 .. occupancy-1, so the oldest holds occupancy-1.
   assign lru_rank       = RANK_W'(occ_ff - OCC_W'(1));
   assign free_vec       = ~valid_vec;
   assign first_free_vec = free_vec & (~free_vec + ENTRIES'(1));
   assign hit            = |match_vec;

   always_comb begin
      hit_rank  = '0;
      hit_key   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_vec[i] && (rank_arr[i] == lru_rank);
         hit_rank      = hit_rank | (rank_arr[i] & {RANK_W{match_vec[i]}});
         hit_key       = hit_key | (key_arr[i] & {lru_kvc_pkg::KEY_W{match_vec[i]}});
         hit_value     = hit_value | (value_arr[i] & {lru_kvc_pkg::VALUE_W{match_vec[i]}});
      end
   end

   always_comb begin
      if (hit) begin
         sel_vec = match_vec;
      end else if (full) begin
         sel_vec = victim_vec;
      end else begin
         sel_vec = first_free_vec;
      end
   end

   always_comb begin
      ctl.fire = fire;
      case (stg_kind_ff)
         lru_kvc_pkg::KIND_GET: begin
            ctl.act = hit ? lru_kvc_pkg::ACT_TOUCH : lru_kvc_pkg::ACT_NONE;
         end
         lru_kvc_pkg::KIND_PUT: begin
            ctl.act = hit ? lru_kvc_pkg::ACT_WRITE : lru_kvc_pkg::ACT_INSERT;
         end
         lru_kvc_pkg::KIND_DELETE: begin
            ctl.act = hit ? lru_kvc_pkg::ACT_REMOVE : lru_kvc_pkg::ACT_NONE;
         end
         default: begin
            ctl.act = lru_kvc_pkg::ACT_NONE;
         end
      endcase
   end

   // An eviction followed by an insert leaves the occupancy unchanged.
   always_comb begin
      occ_in = occ_ff;
      if (fire && ctl.act == lru_kvc_pkg::ACT_INSERT && !full) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (fire && ctl.act == lru_kvc_pkg::ACT_REMOVE) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lru_kvc_cell #(
         .RANK_W (RANK_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel_vec[g]),
         .ref_rank (hit_rank),
         .wr_key   (stg_key_ff),
         .wr_value (stg_value_ff),
         .match    (match_vec[g]),
         .valid    (valid_vec[g]),
         .key      (key_arr[g]),
         .value    (value_arr[g]),
         .rank     (rank_arr[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lru_kvc_pkg::CAP_RESET;
         occ_ff       <= '0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         occ_ff <= occ_in;
         if (req.ready) begin
            stg_valid_ff <= req.valid;
         end
         if (fire && is_get) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req.valid && req.ready) begin
         stg_kind_ff  <= req.kind;
         stg_key_ff   <= req.key;
         stg_value_ff <= req.value;
      end
      if (fire && is_get) begin
         rsp_found_ff <= hit;
         rsp_key_ff   <= hit_key;
         rsp_value_ff <= hit_value;
      end
   end

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key present in more than one entry");

   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy differs from the number of valid entries");

   a_single_victim: assert property (@(posedge clock) disable iff (reset)
      fire && ctl.act == lru_kvc_pkg::ACT_INSERT && full |-> $onehot(victim_vec))
      else $error("eviction without exactly one least recent entry");

   a_get_answers: assert property (@(posedge clock) disable iff (reset)
      fire && is_get |=> rsp_valid_ff)
      else $error("get beat produced no answer");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_key_ff == '0 && rsp_value_ff == '0)
      else $error("miss answer carries non-zero fields");

endmodule

// File: rtl/lru_kvc_cell.sv
module lru_kvc_cell #(
   parameter int RANK_W = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lru_kvc_pkg::ctl_type                   ctl,
   input  logic                                   sel,
   input  logic [RANK_W-1:0]                      ref_rank,
   input  logic [lru_kvc_pkg::KEY_W-1:0]          wr_key,
   input  logic signed [lru_kvc_pkg::VALUE_W-1:0] wr_value,
   output logic                                   match,
   output logic                                   valid,
   output logic [lru_kvc_pkg::KEY_W-1:0]          key,
   output logic signed [lru_kvc_pkg::VALUE_W-1:0] value,
   output logic [RANK_W-1:0]                      rank
);

   logic                                   valid_ff, valid_in;
   logic [RANK_W-1:0]                      rank_ff, rank_in;
   logic [lru_kvc_pkg::KEY_W-1:0]          key_ff, key_in;
   logic signed [lru_kvc_pkg::VALUE_W-1:0] value_ff, value_in;

   assign match = valid_ff && (key_ff == wr_key);
   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign rank  = rank_ff;

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.fire) begin
         case (ctl.act)
            lru_kvc_pkg::ACT_TOUCH, lru_kvc_pkg::ACT_WRITE: begin
               if (sel) begin
                  rank_in = '0;
                  if (ctl.act == lru_kvc_pkg::ACT_WRITE) begin
                     value_in = wr_value;
                  end
               end else if (valid_ff && rank_ff < ref_rank) begin
                  rank_in = rank_ff + RANK_W'(1);
               end
            end
            lru_kvc_pkg::ACT_INSERT: begin
               // The selected slot is either free or the evicted victim.
               if (sel) begin
                  valid_in = 1'b1;
                  rank_in  = '0;
                  key_in   = wr_key;
                  value_in = wr_value;
               end else if (valid_ff) begin
                  rank_in = rank_ff + RANK_W'(1);
               end
            end
            lru_kvc_pkg::ACT_REMOVE: begin
               if (sel) begin
                  valid_in = 1'b0;
                  rank_in  = '0;
               end else if (valid_ff && rank_ff > ref_rank) begin
                  rank_in = rank_ff - RANK_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule
